// ===== rtl/pft_pkg.sv =====
// Shared types and constants for the page table translator.
`default_nettype none

package pft_pkg;

   localparam int FRAMES     = 8;
   localparam int PAGE_BYTES = 32;
   localparam int VADDR_BITS = 16;

   localparam int OFF_W   = $clog2(PAGE_BYTES);
   localparam int PAGE_W  = VADDR_BITS - OFF_W;
   localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   // fixed field widths of the word formats
   localparam int VADDR_FIELD_W = 16;
   localparam int FRAME_FIELD_W = 3;
   localparam int PHYS_FIELD_W  = 8;
   localparam int PAGE_FIELD_W  = 11;
   localparam int CNT_W         = 32;

   localparam logic REQ_TRANSLATE = 1'b0;
   localparam logic REQ_CLEAR     = 1'b1;

   typedef struct packed {
      logic                     req_type;
      logic [VADDR_FIELD_W-1:0] vaddr;
   } pft_req_type;

   typedef struct packed {
      logic                     hit;
      logic [FRAME_FIELD_W-1:0] frame;
      logic [PHYS_FIELD_W-1:0]  phys_addr;
      logic                     load_valid;
      logic [PAGE_FIELD_W-1:0]  load_page;
      logic                     evict_valid;
      logic [PAGE_FIELD_W-1:0]  evict_page;
      logic [CNT_W-1:0]         ref_count;
      logic [CNT_W-1:0]         fault_count;
   } pft_rsp_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic               active;
      logic [PAGE_W-1:0]  page;
      logic               found;
      logic [FRAME_W-1:0] hit_idx;
      logic               empty;
      logic [FRAME_W-1:0] empty_idx;
      logic [PAGE_W-1:0]  victim_page;
   } pft_link_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } pft_state_type;

endpackage

`default_nettype wire

// ===== rtl/pft_cell.sv =====
// One page table entry: holds a frame's page and checks the passing search token.
`default_nettype none

module pft_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [pft_pkg::FRAME_W-1:0] cell_idx,
   input  wire logic [pft_pkg::FRAME_W-1:0] victim_ptr,
   input  wire pft_pkg::pft_link_type link_in,
   output pft_pkg::pft_link_type      link_out,
   input  wire logic                  wr_en,
   input  wire logic [pft_pkg::PAGE_W-1:0] wr_page
);
   import pft_pkg::*;

   logic              valid_ff;
   logic [PAGE_W-1:0] page_ff;
   pft_link_type      link_ff;
   pft_link_type      link_in_nxt;

   always_comb begin
      link_in_nxt = link_in;
      if (link_in.active) begin
         if (!link_in.found && valid_ff && (page_ff == link_in.page)) begin
            link_in_nxt.found   = 1'b1;
            link_in_nxt.hit_idx = cell_idx;
         end
         if (!link_in.empty && !valid_ff) begin
            link_in_nxt.empty     = 1'b1;
            link_in_nxt.empty_idx = cell_idx;
         end
         if (cell_idx == victim_ptr) begin
            link_in_nxt.victim_page = page_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         link_ff  <= '0;
      end else begin
         if (wr_en) begin
            valid_ff <= 1'b1;
         end
         link_ff <= link_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_ff <= wr_page;
      end
   end

   assign link_out = link_ff;

endmodule

`default_nettype wire

// ===== rtl/page_table_fifo_translate_core.sv =====
// Top level: fully associative page table translator with FIFO replacement.
`default_nettype none

// A translate word is accepted when start is high and busy is low. The search
// token walks the row of FRAMES entry cells, one cell per cycle, so busy stays
// high while the token is in the row; the result is registered from the token
// leaving the last cell and appears on rsp_data with rsp_strobe, and the next
// word may be taken in the cycle the strobe is shown. A counter clear word
// leaves busy low and gives its all-zero result in the following cycle. The
// result is present for one cycle only: the receiver must capture it then.
// On a fault the table entry is filled when the result is produced.

module page_table_fifo_translate_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire pft_pkg::pft_req_type req_data,
   output logic                      rsp_strobe,
   output pft_pkg::pft_rsp_type      rsp_data
);
   import pft_pkg::*;

   pft_state_type      state_ff, state_in;
   logic [FRAME_W-1:0] victim_ff, victim_in;
   logic [CNT_W-1:0]   ref_ff, ref_in;
   logic [CNT_W-1:0]   fault_ff, fault_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   pft_rsp_type        rsp_ff, rsp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   pft_link_type       links [FRAMES+1];
   pft_link_type       tail;
   logic               accept;
   logic               fill_en;
   logic [FRAME_W-1:0] fill_idx;
   logic [FRAMES-1:0]  cell_wr;
   logic [VADDR_BITS-1:0] va;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
   endfunction

   assign accept = start && !busy;
   assign va     = VADDR_BITS'(req_data.vaddr);
   assign tail   = links[FRAMES];

   assign links[0] = '{active:  accept && (req_data.req_type == REQ_TRANSLATE),
                       page:    va[VADDR_BITS-1:OFF_W],
                       default: '0};

   genvar gi;
   generate
      for (gi = 0; gi < FRAMES; gi++) begin : g_cell
         assign cell_wr[gi] = fill_en && (fill_idx == FRAME_W'(gi));
         pft_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_idx   (FRAME_W'(gi)),
            .victim_ptr (victim_ff),
            .link_in    (links[gi]),
            .link_out   (links[gi+1]),
            .wr_en      (cell_wr[gi]),
            .wr_page    (tail.page)
         );
      end
   endgenerate

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.req_type == REQ_TRANSLATE)) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tail.active) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      unique case (state_ff)
         ST_IDLE:   busy = 1'b0;
         ST_SEARCH: busy = 1'b1;
         default:   busy = 1'b1;
      endcase
   end

   // result assembly for clear words, and result and table update when the token leaves the last cell
   always_comb begin
      logic [FRAME_W-1:0] fr;
      logic [CNT_W-1:0]   ref_nxt;
      logic [CNT_W-1:0]   fault_nxt;
      logic [CNT_W-1:0]   phys_wide;

      victim_in     = victim_ff;
      ref_in        = ref_ff;
      fault_in      = fault_ff;
      off_in        = off_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      fill_en       = 1'b0;
      fill_idx      = '0;
      fr            = '0;
      ref_nxt       = sat_inc(ref_ff);
      fault_nxt     = sat_inc(fault_ff);
      phys_wide     = '0;

      if (accept) begin
         off_in = va[OFF_W-1:0];
         if (req_data.req_type == REQ_CLEAR) begin
            ref_in        = '0;
            fault_in      = '0;
            rsp_in        = '0;
            rsp_strobe_in = 1'b1;
         end
      end

      if (tail.active) begin
         rsp_in           = '0;
         rsp_strobe_in    = 1'b1;
         ref_in           = ref_nxt;
         rsp_in.ref_count = ref_nxt;
         if (tail.found) begin
            fr         = tail.hit_idx;
            rsp_in.hit = 1'b1;
            rsp_in.fault_count = fault_ff;
         end else begin
            fault_in           = fault_nxt;
            rsp_in.fault_count = fault_nxt;
            rsp_in.load_valid  = 1'b1;
            rsp_in.load_page   = PAGE_FIELD_W'(tail.page);
            if (tail.empty) begin
               fr = tail.empty_idx;
            end else begin
               fr                 = victim_ff;
               rsp_in.evict_valid = 1'b1;
               rsp_in.evict_page  = PAGE_FIELD_W'(tail.victim_page);
               victim_in = (victim_ff == FRAME_W'(FRAMES - 1)) ? '0
                                                               : victim_ff + FRAME_W'(1);
            end
            fill_en  = 1'b1;
            fill_idx = fr;
         end
         phys_wide        = CNT_W'({fr, off_ff});
         rsp_in.frame     = FRAME_FIELD_W'(fr);
         rsp_in.phys_addr = phys_wide[PHYS_FIELD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         victim_ff     <= '0;
         ref_ff        <= '0;
         fault_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         victim_ff     <= victim_in;
         ref_ff        <= ref_in;
         fault_ff      <= fault_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire
